@@ rtl/core/dcfp_pkg.sv @@
// ---------------------------------------------------------------------------
// dcfp_pkg: shared types and constants of the command frame parser
// Token format between the framing front end and the field decoder, the
// result record, and the ASCII codes and limits used by the parser.
// ---------------------------------------------------------------------------
package dcfp_pkg;

    // ASCII codes
    localparam logic [7:0] CH_COLOR_OPEN  = 8'h3C; // '<'
    localparam logic [7:0] CH_COLOR_CLOSE = 8'h3E; // '>'
    localparam logic [7:0] CH_TONE_OPEN   = 8'h5B; // '['
    localparam logic [7:0] CH_TONE_CLOSE  = 8'h5D; // ']'
    localparam logic [7:0] CH_COMMA       = 8'h2C;
    localparam logic [7:0] CH_PLUS        = 8'h2B;
    localparam logic [7:0] CH_MINUS       = 8'h2D;
    localparam logic [7:0] CH_SPACE       = 8'h20;
    localparam logic [7:0] CH_TAB         = 8'h09;
    localparam logic [7:0] CH_CR          = 8'h0D;
    localparam logic [7:0] CH_ZERO        = 8'h30;
    localparam logic [7:0] CH_NINE        = 8'h39;
    localparam logic [7:0] CH_NUL         = 8'h00;

    localparam int MAG_W = 15;
    localparam int MS_W  = 13;

    localparam logic [MAG_W-1:0] MAG_SAT    = 15'd32767;
    localparam logic [MAG_W-1:0] LIM_COLOR  = 15'd255;
    localparam logic [MAG_W-1:0] LIM_FREQ   = 15'd20000;
    localparam logic [MAG_W-1:0] LIM_DUR    = 15'd5000;

    localparam logic [1:0] IDX_LAST_COLOR = 2'd2;
    localparam logic [1:0] IDX_LAST_TONE  = 2'd1;

    localparam logic CMD_COLOR = 1'b0;
    localparam logic CMD_TONE  = 1'b1;

    typedef enum logic [1:0] {
        TOK_OPEN  = 2'd0,
        TOK_BODY  = 2'd1,
        TOK_CLOSE = 2'd2
    } t_tok_kind;

    typedef enum logic [1:0] {
        PH_WS     = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        t_tok_kind  kind;
        logic       tone;
        logic [7:0] data;
    } t_token;

    typedef struct packed {
        logic             command_kind;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [MAG_W-1:0] tone_hz;
        logic [MS_W-1:0]  tone_ms;
    } t_result;

endpackage

@@ rtl/core/dcfp_fifo.sv @@
// ---------------------------------------------------------------------------
// dcfp_fifo: small register queue
// Registered storage with full/empty flags; push and pop may happen in the
// same cycle.
// ---------------------------------------------------------------------------
module dcfp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/core/dcfp_front.sv @@
// ---------------------------------------------------------------------------
// dcfp_front: frame tracker
// Finds openers and closers, counts body bytes and turns accepted frame bytes
// into open, body or close tokens for the decoder.
// ---------------------------------------------------------------------------
module dcfp_front #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    output logic            o_tok_push,
    output dcfp_pkg::t_token o_tok
);
    localparam int CW = $clog2(BUFFER_BYTES);

    logic          r_in_frame, n_in_frame;
    logic          r_tone, n_tone;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    w_closer;

    assign w_closer = r_tone ? dcfp_pkg::CH_TONE_CLOSE : dcfp_pkg::CH_COLOR_CLOSE;

    always_comb begin
        n_in_frame    = r_in_frame;
        n_tone        = r_tone;
        n_count       = r_count;
        o_tok_push    = 1'b0;
        o_tok.kind    = dcfp_pkg::TOK_BODY;
        o_tok.tone    = r_tone;
        o_tok.data    = i_byte;
        if (i_valid) begin
            if (i_byte == dcfp_pkg::CH_COLOR_OPEN || i_byte == dcfp_pkg::CH_TONE_OPEN) begin
                n_in_frame = 1'b1;
                n_tone     = (i_byte == dcfp_pkg::CH_TONE_OPEN);
                n_count    = '0;
                o_tok_push = 1'b1;
                o_tok.kind = dcfp_pkg::TOK_OPEN;
                o_tok.tone = (i_byte == dcfp_pkg::CH_TONE_OPEN);
            end else if (r_in_frame) begin
                if (i_byte == w_closer) begin
                    n_in_frame = 1'b0;
                    o_tok_push = 1'b1;
                    o_tok.kind = dcfp_pkg::TOK_CLOSE;
                end else if (r_count != CW'(BUFFER_BYTES - 1)) begin
                    n_count    = r_count + 1'b1;
                    o_tok_push = 1'b1;
                end else begin
                    // body overflow: drop the frame, decoder is reset by next opener
                    n_in_frame = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_tone     <= 1'b0;
            r_count    <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_tone     <= n_tone;
            r_count    <= n_count;
        end
    end

endmodule

@@ rtl/core/dcfp_back.sv @@
// ---------------------------------------------------------------------------
// dcfp_back: field decoder
// Runs the %d field decode one byte per token, keeps the clamped fields and
// builds a result when a well-formed frame closes and no tone field is zero.
// ---------------------------------------------------------------------------
module dcfp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tok_valid,
    input  dcfp_pkg::t_token  i_tok,
    output logic              o_res_push,
    output dcfp_pkg::t_result o_res
);
    localparam int MW = dcfp_pkg::MAG_W;
    localparam int SW = dcfp_pkg::MS_W;

    function automatic logic [MW-1:0] clamp_field(
        input logic [MW-1:0] mag,
        input logic          neg,
        input logic [MW-1:0] lim
    );
        logic [MW-1:0] v;
        v = neg ? '0 : ((mag > lim) ? lim : mag);
        return v;
    endfunction

    logic             r_tone, n_tone;
    logic [1:0]       r_idx, n_idx;
    dcfp_pkg::t_phase r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [MW-1:0]    r_mag, n_mag;
    logic             r_fail, n_fail;
    logic [MW-1:0]    r_first, n_first;
    logic [SW-1:0]    r_second, n_second;

    logic [7:0]    w_c;
    logic          w_digit, w_ws, w_handled;
    logic [1:0]    w_last;
    logic [18:0]   w_prod;
    logic [MW-1:0] w_lim0, w_lim1, w_lim_last, w_fin, w_clamp0, w_clamp1;
    logic          w_ok;

    assign w_c     = i_tok.data;
    assign w_digit = (w_c >= dcfp_pkg::CH_ZERO) && (w_c <= dcfp_pkg::CH_NINE);
    assign w_ws    = (w_c == dcfp_pkg::CH_SPACE) ||
                     ((w_c >= dcfp_pkg::CH_TAB) && (w_c <= dcfp_pkg::CH_CR));
    assign w_last  = r_tone ? dcfp_pkg::IDX_LAST_TONE : dcfp_pkg::IDX_LAST_COLOR;
    assign w_prod  = {4'b0, r_mag} * 19'd10 + {15'b0, w_c[3:0]};

    assign w_lim0     = r_tone ? dcfp_pkg::LIM_FREQ : dcfp_pkg::LIM_COLOR;
    assign w_lim1     = r_tone ? dcfp_pkg::LIM_DUR  : dcfp_pkg::LIM_COLOR;
    assign w_lim_last = r_tone ? w_lim1 : dcfp_pkg::LIM_COLOR;
    assign w_clamp0   = clamp_field(r_mag, r_neg, w_lim0);
    assign w_clamp1   = clamp_field(r_mag, r_neg, w_lim1);
    assign w_fin      = clamp_field(r_mag, r_neg, w_lim_last);
    assign w_ok       = !r_fail && ((r_phase == dcfp_pkg::PH_DONE) ||
                        (r_phase == dcfp_pkg::PH_DIGITS && r_idx == w_last));

    always_comb begin
        n_tone     = r_tone;
        n_idx      = r_idx;
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_mag      = r_mag;
        n_fail     = r_fail;
        n_first    = r_first;
        n_second   = r_second;
        w_handled  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;

        if (i_tok_valid) begin
            case (i_tok.kind)
                dcfp_pkg::TOK_OPEN, dcfp_pkg::TOK_CLOSE: begin
                    if (i_tok.kind == dcfp_pkg::TOK_CLOSE && w_ok) begin
                        if (!r_tone) begin
                            o_res_push         = 1'b1;
                            o_res.command_kind = dcfp_pkg::CMD_COLOR;
                            o_res.red          = r_first[7:0];
                            o_res.green        = r_second[7:0];
                            o_res.blue         = w_fin[7:0];
                        end else if (r_first != '0 && w_fin != '0) begin
                            o_res_push         = 1'b1;
                            o_res.command_kind = dcfp_pkg::CMD_TONE;
                            o_res.tone_hz      = r_first;
                            o_res.tone_ms      = w_fin[SW-1:0];
                        end
                    end
                    if (i_tok.kind == dcfp_pkg::TOK_OPEN) begin
                        n_tone = i_tok.tone;
                    end
                    n_idx    = '0;
                    n_phase  = dcfp_pkg::PH_WS;
                    n_neg    = 1'b0;
                    n_mag    = '0;
                    n_fail   = 1'b0;
                    n_first  = '0;
                    n_second = '0;
                end
                dcfp_pkg::TOK_BODY: begin
                    if (!r_fail && r_phase != dcfp_pkg::PH_DONE) begin
                        if (w_c == dcfp_pkg::CH_NUL) begin
                            // NUL ends the text
                            if (r_phase == dcfp_pkg::PH_DIGITS && r_idx == w_last) begin
                                n_phase = dcfp_pkg::PH_DONE;
                            end else begin
                                n_fail = 1'b1;
                            end
                        end else begin
                            if (r_phase == dcfp_pkg::PH_WS) begin
                                if (w_ws) begin
                                    w_handled = 1'b1;
                                end else if (w_c == dcfp_pkg::CH_PLUS ||
                                             w_c == dcfp_pkg::CH_MINUS) begin
                                    n_neg     = (w_c == dcfp_pkg::CH_MINUS);
                                    n_phase   = dcfp_pkg::PH_SIGN;
                                    w_handled = 1'b1;
                                end
                            end
                            if (!w_handled && (r_phase == dcfp_pkg::PH_WS ||
                                               r_phase == dcfp_pkg::PH_SIGN)) begin
                                if (!w_digit) begin
                                    n_fail    = 1'b1;
                                    w_handled = 1'b1;
                                end else begin
                                    n_phase = dcfp_pkg::PH_DIGITS;
                                end
                            end
                            if (!w_handled) begin
                                if (w_digit) begin
                                    n_mag = (w_prod > {4'b0, dcfp_pkg::MAG_SAT}) ?
                                            dcfp_pkg::MAG_SAT : w_prod[MW-1:0];
                                end else if (r_idx == w_last) begin
                                    n_phase = dcfp_pkg::PH_DONE;
                                end else if (w_c != dcfp_pkg::CH_COMMA) begin
                                    n_fail = 1'b1;
                                end else begin
                                    if (r_idx == 2'd0) begin
                                        n_first = w_clamp0;
                                    end else begin
                                        n_second = w_clamp1[SW-1:0];
                                    end
                                    n_idx   = r_idx + 1'b1;
                                    n_phase = dcfp_pkg::PH_WS;
                                    n_neg   = 1'b0;
                                    n_mag   = '0;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone   <= 1'b0;
            r_idx    <= '0;
            r_phase  <= dcfp_pkg::PH_WS;
            r_neg    <= 1'b0;
            r_mag    <= '0;
            r_fail   <= 1'b0;
            r_first  <= '0;
            r_second <= '0;
        end else begin
            r_tone   <= n_tone;
            r_idx    <= n_idx;
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_mag    <= n_mag;
            r_fail   <= n_fail;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

endmodule

@@ rtl/core/delimited_command_frame_parser.sv @@
// Result path: a closing byte is queued as a close token when it is
//   transferred; the decoder pops that token once the output queue has
//   room and writes the result into the output queue.
// Throughput: one byte per cycle while full is low; both 2-entry queues let
//   each side stall on its own.
// Reset (synchronous, active low): no frame open, decoder cleared, queues empty.
// ---------------------------------------------------------------------------
// delimited_command_frame_parser: serial color/tone command frame parser
// Frame tracker feeds tokens through a short queue to the field decoder,
// whose results wait in an output queue.
// ---------------------------------------------------------------------------
module delimited_command_frame_parser #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_byte_in,
    output logic        empty,
    input  logic        pop,
    output logic        o_command_kind,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [14:0] o_tone_hz,
    output logic [12:0] o_tone_ms
);
    localparam int TOK_W = $bits(dcfp_pkg::t_token);
    localparam int RES_W = $bits(dcfp_pkg::t_result);

    logic              w_accept;
    logic              w_tok_push, w_tok_full, w_tok_empty, w_tok_pop;
    dcfp_pkg::t_token  w_tok_in, w_tok_out;
    logic              w_res_push, w_res_full;
    dcfp_pkg::t_result w_res_in, w_res_out;
    logic [TOK_W-1:0]  w_tok_out_bits;
    logic [RES_W-1:0]  w_res_out_bits;

    assign full     = w_tok_full;
    assign w_accept = push && !w_tok_full;

    dcfp_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_byte     (i_byte_in),
        .o_tok_push (w_tok_push),
        .o_tok      (w_tok_in)
    );

    dcfp_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (2)
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_tok_push),
        .i_data  (w_tok_in),
        .o_full  (w_tok_full),
        .i_pop   (w_tok_pop),
        .o_data  (w_tok_out_bits),
        .o_empty (w_tok_empty)
    );

    assign w_tok_out = dcfp_pkg::t_token'(w_tok_out_bits);
    // decoder advances only when a result, if any, has room
    assign w_tok_pop = !w_tok_empty && !w_res_full;

    dcfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_tok_pop),
        .i_tok       (w_tok_out),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    dcfp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out_bits),
        .o_empty (empty)
    );

    assign w_res_out      = dcfp_pkg::t_result'(w_res_out_bits);
    assign o_command_kind = w_res_out.command_kind;
    assign o_red          = w_res_out.red;
    assign o_green        = w_res_out.green;
    assign o_blue         = w_res_out.blue;
    assign o_tone_hz      = w_res_out.tone_hz;
    assign o_tone_ms      = w_res_out.tone_ms;

endmodule

@@ tb/delimited_command_frame_parser_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// delimited_command_frame_parser_test: self-checking bench for the parser
// Feeds byte streams of color and tone frames (directed corner frames, then
// random well-formed and broken frames with noise in between), predicts each
// command in a bench-side decoder and compares every popped result with it.
// ---------------------------------------------------------------------------
module delimited_command_frame_parser_test;

    localparam int BUFFER_BYTES = 32;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_BYTES  = 470;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_byte_in = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_command_kind;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [14:0] o_tone_hz;
    logic [12:0] o_tone_ms;

    delimited_command_frame_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_byte_in      (i_byte_in),
        .empty          (empty),
        .pop            (pop),
        .o_command_kind (o_command_kind),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_tone_hz      (o_tone_hz),
        .o_tone_ms      (o_tone_ms)
    );

    logic [7:0]        byte_backlog[$];
    dcfp_pkg::t_result expected_cmds[$];
    int                frame_bytes_queued = 0;
    int                send_idle_pct = 33;
    int                recv_idle_pct = 74;
    int                mismatches = 0;
    int                quiet_cycles = 0;

    // bench-side decoder state
    logic             frame_open = 1'b0;
    logic             frame_is_tone = 1'b0;
    int               body_len = 0;
    logic [1:0]       field_idx = 2'd0;
    dcfp_pkg::t_phase scan_phase = dcfp_pkg::PH_WS;
    logic             field_neg = 1'b0;
    logic [14:0]      field_mag = '0;
    logic             body_failed = 1'b0;
    logic [14:0]      held_first = '0;
    logic [12:0]      held_second = '0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // ---------------- decoder model ----------------
    task automatic clear_fields();
        body_len    = 0;
        field_idx   = 2'd0;
        scan_phase  = dcfp_pkg::PH_WS;
        field_neg   = 1'b0;
        field_mag   = '0;
        body_failed = 1'b0;
        held_first  = '0;
        held_second = '0;
    endtask

    function automatic logic is_space(input logic [7:0] c);
        return c == dcfp_pkg::CH_SPACE || (c >= dcfp_pkg::CH_TAB && c <= dcfp_pkg::CH_CR);
    endfunction

    function automatic logic [14:0] clamped_field(input logic [1:0] idx);
        logic [14:0] cap;
        if (!frame_is_tone)
            cap = dcfp_pkg::LIM_COLOR;
        else
            cap = (idx == 2'd0) ? dcfp_pkg::LIM_FREQ : dcfp_pkg::LIM_DUR;
        if (field_neg)
            return '0;
        return (field_mag > cap) ? cap : field_mag;
    endfunction

    task automatic scan_body_char(input logic [7:0] c);
        logic [1:0]  last_idx;
        logic        is_digit;
        int unsigned acc;
        logic [14:0] val;
        last_idx = frame_is_tone ? dcfp_pkg::IDX_LAST_TONE : dcfp_pkg::IDX_LAST_COLOR;
        is_digit = (c >= dcfp_pkg::CH_ZERO && c <= dcfp_pkg::CH_NINE);
        if (body_failed || scan_phase == dcfp_pkg::PH_DONE)
            return;
        // NUL terminates the text: fine only inside the digits of the last field
        if (c == dcfp_pkg::CH_NUL) begin
            if (scan_phase == dcfp_pkg::PH_DIGITS && field_idx == last_idx)
                scan_phase = dcfp_pkg::PH_DONE;
            else
                body_failed = 1'b1;
            return;
        end
        if (scan_phase == dcfp_pkg::PH_WS) begin
            if (is_space(c))
                return;
            if (c == dcfp_pkg::CH_PLUS || c == dcfp_pkg::CH_MINUS) begin
                field_neg  = (c == dcfp_pkg::CH_MINUS);
                scan_phase = dcfp_pkg::PH_SIGN;
                return;
            end
        end
        if (scan_phase != dcfp_pkg::PH_DIGITS) begin
            if (!is_digit) begin
                body_failed = 1'b1;
                return;
            end
            scan_phase = dcfp_pkg::PH_DIGITS;
        end
        if (is_digit) begin
            acc = int'(field_mag) * 10 + int'(c - dcfp_pkg::CH_ZERO);
            field_mag = (acc > dcfp_pkg::MAG_SAT) ? dcfp_pkg::MAG_SAT : acc[14:0];
            return;
        end
        // text after the last field is ignored
        if (field_idx == last_idx) begin
            scan_phase = dcfp_pkg::PH_DONE;
            return;
        end
        if (c != dcfp_pkg::CH_COMMA) begin
            body_failed = 1'b1;
            return;
        end
        val = clamped_field(field_idx);
        if (field_idx == 2'd0)
            held_first = val;
        else
            held_second = val[12:0];
        field_idx  = field_idx + 2'd1;
        scan_phase = dcfp_pkg::PH_WS;
        field_neg  = 1'b0;
        field_mag  = '0;
    endtask

    task automatic advance_frame(input logic [7:0] c);
        logic [7:0]        closer;
        logic [1:0]        last_idx;
        logic [14:0]       final_val;
        dcfp_pkg::t_result cmd;
        if (c == dcfp_pkg::CH_COLOR_OPEN || c == dcfp_pkg::CH_TONE_OPEN) begin
            frame_open    = 1'b1;
            frame_is_tone = (c == dcfp_pkg::CH_TONE_OPEN);
            clear_fields();
            return;
        end
        if (!frame_open)
            return;
        closer   = frame_is_tone ? dcfp_pkg::CH_TONE_CLOSE : dcfp_pkg::CH_COLOR_CLOSE;
        last_idx = frame_is_tone ? dcfp_pkg::IDX_LAST_TONE : dcfp_pkg::IDX_LAST_COLOR;
        if (c == closer) begin
            if (!body_failed && (scan_phase == dcfp_pkg::PH_DONE ||
                    (scan_phase == dcfp_pkg::PH_DIGITS && field_idx == last_idx))) begin
                final_val = clamped_field(last_idx);
                cmd = '0;
                if (!frame_is_tone) begin
                    cmd.command_kind = dcfp_pkg::CMD_COLOR;
                    cmd.red   = held_first[7:0];
                    cmd.green = held_second[7:0];
                    cmd.blue  = final_val[7:0];
                    expected_cmds.push_back(cmd);
                end else if (held_first != 0 && final_val != 0) begin
                    cmd.command_kind = dcfp_pkg::CMD_TONE;
                    cmd.tone_hz = held_first;
                    cmd.tone_ms = final_val[12:0];
                    expected_cmds.push_back(cmd);
                end
            end
            frame_open = 1'b0;
            clear_fields();
            return;
        end
        // body overflow drops the frame silently
        if (body_len < BUFFER_BYTES - 1) begin
            body_len++;
            scan_body_char(c);
        end else begin
            frame_open = 1'b0;
            clear_fields();
        end
    endtask

    // ---------------- stimulus ----------------
    task automatic add_frame_byte(input logic [7:0] b);
        byte_backlog.push_back(b);
        frame_bytes_queued++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_frame_byte(s[i]);
    endtask

    task automatic add_padded_color(input int zeros);
        add_frame_byte(dcfp_pkg::CH_COLOR_OPEN);
        repeat (zeros) add_frame_byte(dcfp_pkg::CH_ZERO);
        add_text("1,2,3>");
    endtask

    task automatic queue_directed();
        add_text("<0,0,0>");
        add_text("<255,255,255>");
        add_text("< 7,\t+300,-0>");
        add_text("[20000,5000]");
        add_text("[99999999,32768]");
        add_text("[0,5]");
        add_text("[-3,5]");
        add_text("[ \n+1,\r\v\f1]");
        add_text("xyz>]9");
        add_text("<1,2>");
        add_text("<,1,2>");
        add_text("<+,1,2>");
        add_text("<1;2;3>");
        add_text("<1 ,2,3>");
        add_text("<1,2,3xyz]>");
        add_text("<1,2[5,6]");
        add_text("[12,34");
        add_frame_byte(dcfp_pkg::CH_NUL);
        add_text("zz]");
        add_text("<1,2");
        add_frame_byte(dcfp_pkg::CH_NUL);
        add_text(",3>");
        add_padded_color(26);   // exactly the longest body that fits
        add_padded_color(27);   // one body byte too many
    endtask

    task automatic queue_random_frame();
        int         tone_sel;
        int         nfields;
        int         flaw;
        int         nd;
        int         sel;
        logic [7:0] b;
        tone_sel = $urandom_range(1);
        nfields  = tone_sel ? 2 : 3;
        flaw     = $urandom_range(11);   // 1..5 put a flaw into the frame
        add_frame_byte(tone_sel ? dcfp_pkg::CH_TONE_OPEN : dcfp_pkg::CH_COLOR_OPEN);
        if (flaw == 1)
            nfields--;
        for (int f = 0; f < nfields; f++) begin
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    sel = $urandom_range(5);
                    add_frame_byte(sel == 5 ? dcfp_pkg::CH_SPACE :
                                   dcfp_pkg::CH_TAB + 8'(sel));
                end
            end
            sel = $urandom_range(7);
            if (sel == 0)
                add_frame_byte(dcfp_pkg::CH_MINUS);
            else if (sel == 1)
                add_frame_byte(dcfp_pkg::CH_PLUS);
            nd = ($urandom_range(4) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
            if (flaw == 2 && f == 1)
                nd = 0;
            repeat (nd) add_frame_byte(dcfp_pkg::CH_ZERO + 8'($urandom_range(9)));
            if (f < nfields - 1) begin
                b = (flaw == 3 && f == 0) ? 8'($urandom_range(255)) : dcfp_pkg::CH_COMMA;
                add_frame_byte(b);
            end
        end
        sel = $urandom_range(7);
        if (sel == 0) begin
            repeat ($urandom_range(1, 3)) add_frame_byte(8'h61 + 8'($urandom_range(25)));
        end else if (sel == 1) begin
            add_frame_byte(dcfp_pkg::CH_NUL);
            add_frame_byte(8'($urandom_range(255)));
        end
        if (flaw == 4)
            add_frame_byte(tone_sel ? dcfp_pkg::CH_COLOR_CLOSE : dcfp_pkg::CH_TONE_CLOSE);
        if (flaw != 5)
            add_frame_byte(tone_sel ? dcfp_pkg::CH_TONE_CLOSE : dcfp_pkg::CH_COLOR_CLOSE);
        // line noise between frames
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) byte_backlog.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic queue_random_frames(input int nbytes);
        int goal;
        goal = frame_bytes_queued + nbytes;
        while (frame_bytes_queued < goal)
            queue_random_frame();
    endtask

    task automatic drain_backlog();
        while (byte_backlog.size() != 0 || push)
            @(posedge i_clk);
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full)
                advance_frame(i_byte_in);
            if (!push || !full) begin
                if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    push      <= 1'b1;
                    i_byte_in <= byte_backlog.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        dcfp_pkg::t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, kind %0d", o_command_kind));
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("command_kind", o_command_kind, want.command_kind);
                    check_field("red", o_red, want.red);
                    check_field("green", o_green, want.green);
                    check_field("blue", o_blue, want.blue);
                    check_field("tone_hz", o_tone_hz, want.tone_hz);
                    check_field("tone_ms", o_tone_ms, want.tone_ms);
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        queue_directed();
        queue_random_frames(PHASE_BYTES);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain_backlog();

        send_idle_pct = 74;
        recv_idle_pct = 33;
        queue_random_frames(PHASE_BYTES);
        drain_backlog();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_frames(PHASE_BYTES);
        drain_backlog();

        while (expected_cmds.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
